// ----- rtl/cawf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cawf_pkg
// Shared types and constants of the 8-bit ALU with flags.
// ----------------------------------------------------------------------------
package cawf_pkg;

    localparam int KIND_W  = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int IDX_W   = 3;

    // s_axis_tdata: operand_a, operand_b, bit_index, Z, N, H, C, zero pad
    localparam int S_TDATA_W = 40;
    // m_axis_tdata: result, write_back, Z, N, H, C, zero pad
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - WORD_W - 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 5'd0,
        KIND_ADC   = 5'd1,
        KIND_SUB   = 5'd2,
        KIND_SBC   = 5'd3,
        KIND_AND   = 5'd4,
        KIND_XOR   = 5'd5,
        KIND_OR    = 5'd6,
        KIND_CP    = 5'd7,
        KIND_INC   = 5'd8,
        KIND_DEC   = 5'd9,
        KIND_DAA   = 5'd10,
        KIND_CPL   = 5'd11,
        KIND_SCF   = 5'd12,
        KIND_CCF   = 5'd13,
        KIND_RLC   = 5'd14,
        KIND_RRC   = 5'd15,
        KIND_RL    = 5'd16,
        KIND_RR    = 5'd17,
        KIND_SLA   = 5'd18,
        KIND_SRA   = 5'd19,
        KIND_SWAP  = 5'd20,
        KIND_SRL   = 5'd21,
        KIND_BIT   = 5'd22,
        KIND_RES   = 5'd23,
        KIND_SET   = 5'd24,
        KIND_ADD16 = 5'd25,
        KIND_ADDSP = 5'd26
    } t_kind;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  operand_a;
        logic [WORD_W-1:0]  operand_b;
        logic [IDX_W-1:0]   bit_index;
        t_flags             flags;
    } t_alu_in;

    typedef struct packed {
        logic [WORD_W-1:0]  result;
        logic               write_back;
        t_flags             flags;
    } t_alu_out;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic               carry;
    } t_shift_out;

endpackage
`default_nettype wire

// ----- rtl/cawf_shift.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cawf_shift
// Rotate, shift and nibble swap of one byte, with carry out.
// ----------------------------------------------------------------------------
module cawf_shift (
    input  var cawf_pkg::t_kind              i_kind,
    input  var logic [cawf_pkg::BYTE_W-1:0]  i_value,
    input  var logic                         i_carry,
    output var cawf_pkg::t_shift_out         o_shift
);

    localparam int BW = cawf_pkg::BYTE_W;
    localparam int NW = cawf_pkg::NIB_W;

    always_comb begin
        case (i_kind)
            cawf_pkg::KIND_RLC: begin
                o_shift.value = {i_value[BW-2:0], i_value[BW-1]};
                o_shift.carry = i_value[BW-1];
            end
            cawf_pkg::KIND_RRC: begin
                o_shift.value = {i_value[0], i_value[BW-1:1]};
                o_shift.carry = i_value[0];
            end
            cawf_pkg::KIND_RL: begin
                o_shift.value = {i_value[BW-2:0], i_carry};
                o_shift.carry = i_value[BW-1];
            end
            cawf_pkg::KIND_RR: begin
                o_shift.value = {i_carry, i_value[BW-1:1]};
                o_shift.carry = i_value[0];
            end
            cawf_pkg::KIND_SLA: begin
                o_shift.value = {i_value[BW-2:0], 1'b0};
                o_shift.carry = i_value[BW-1];
            end
            cawf_pkg::KIND_SRA: begin
                o_shift.value = {i_value[BW-1], i_value[BW-1:1]};
                o_shift.carry = i_value[0];
            end
            cawf_pkg::KIND_SWAP: begin
                o_shift.value = {i_value[NW-1:0], i_value[BW-1:NW]};
                o_shift.carry = 1'b0;
            end
            cawf_pkg::KIND_SRL: begin
                o_shift.value = {1'b0, i_value[BW-1:1]};
                o_shift.carry = i_value[0];
            end
            default: begin
                o_shift.value = '0;
                o_shift.carry = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/cawf_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cawf_alu
// Single-pass datapath: result, write-back mark and flags for one operation.
// ----------------------------------------------------------------------------
module cawf_alu (
    input  var cawf_pkg::t_alu_in   i_op,
    output var cawf_pkg::t_alu_out  o_res
);

    localparam int BW = cawf_pkg::BYTE_W;
    localparam int WW = cawf_pkg::WORD_W;
    localparam int NW = cawf_pkg::NIB_W;

    localparam logic [BW-1:0] DAA_HI  = 8'h60;
    localparam logic [BW-1:0] DAA_LO  = 8'h06;
    localparam logic [BW-1:0] BCD_MAX = 8'h99;
    localparam logic [NW-1:0] DIG_MAX = 4'h9;

    logic [BW-1:0]  a;
    logic [BW-1:0]  b;
    logic           add_ci;
    logic           sub_ci;
    logic [BW:0]    add_sum;
    logic [NW:0]    add_half;
    logic [BW:0]    sub_diff;
    logic [NW:0]    sub_half;
    logic [BW-1:0]  inc_val;
    logic [BW-1:0]  dec_val;
    logic [BW-1:0]  bit_mask;
    logic [WW:0]    w_sum;
    logic [12:0]    w_half;
    logic [WW-1:0]  sp_sum;
    logic [BW-1:0]  daa_val;
    logic [BW-1:0]  daa_step;
    logic           daa_c;

    cawf_pkg::t_shift_out shift_res;

    assign a = i_op.operand_a[BW-1:0];
    assign b = i_op.operand_b[BW-1:0];

    // Carry / borrow in only for ADC and SBC
    assign add_ci = (i_op.kind == cawf_pkg::KIND_ADC) & i_op.flags.c;
    assign sub_ci = (i_op.kind == cawf_pkg::KIND_SBC) & i_op.flags.c;

    assign add_sum  = {1'b0, a} + {1'b0, b} + {{BW{1'b0}}, add_ci};
    assign add_half = {1'b0, a[NW-1:0]} + {1'b0, b[NW-1:0]} + {{NW{1'b0}}, add_ci};
    // Bit 8 / bit 4 of the wrapped difference is the borrow
    assign sub_diff = {1'b0, a} - {1'b0, b} - {{BW{1'b0}}, sub_ci};
    assign sub_half = {1'b0, a[NW-1:0]} - {1'b0, b[NW-1:0]} - {{NW{1'b0}}, sub_ci};

    assign inc_val  = b + 8'd1;
    assign dec_val  = b - 8'd1;
    assign bit_mask = 8'd1 << i_op.bit_index;

    assign w_sum  = {1'b0, i_op.operand_a} + {1'b0, i_op.operand_b};
    assign w_half = {1'b0, i_op.operand_a[11:0]} + {1'b0, i_op.operand_b[11:0]};
    assign sp_sum = i_op.operand_a + {{(WW-BW){b[BW-1]}}, b};

    // Decimal adjust
    always_comb begin
        daa_step = a;
        daa_c    = i_op.flags.c;
        if (!i_op.flags.n) begin
            if (i_op.flags.c || (a > BCD_MAX)) begin
                daa_step = a + DAA_HI;
                daa_c    = 1'b1;
            end
            if (i_op.flags.h || (a[NW-1:0] > DIG_MAX)) begin
                daa_val = daa_step + DAA_LO;
            end else begin
                daa_val = daa_step;
            end
        end else begin
            if (i_op.flags.c) begin
                daa_step = a - DAA_HI;
            end
            if (i_op.flags.h) begin
                daa_val = daa_step - DAA_LO;
            end else begin
                daa_val = daa_step;
            end
        end
    end

    cawf_shift u_shift (
        .i_kind  (i_op.kind),
        .i_value (b),
        .i_carry (i_op.flags.c),
        .o_shift (shift_res)
    );

    always_comb begin
        o_res.result     = '0;
        o_res.write_back = 1'b1;
        o_res.flags      = i_op.flags;
        case (i_op.kind)
            cawf_pkg::KIND_ADD, cawf_pkg::KIND_ADC: begin
                o_res.result[BW-1:0] = add_sum[BW-1:0];
                o_res.flags.z = (add_sum[BW-1:0] == '0);
                o_res.flags.n = 1'b0;
                o_res.flags.h = add_half[NW];
                o_res.flags.c = add_sum[BW];
            end
            cawf_pkg::KIND_SUB, cawf_pkg::KIND_SBC: begin
                o_res.result[BW-1:0] = sub_diff[BW-1:0];
                o_res.flags.z = (sub_diff[BW-1:0] == '0);
                o_res.flags.n = 1'b1;
                o_res.flags.h = sub_half[NW];
                o_res.flags.c = sub_diff[BW];
            end
            cawf_pkg::KIND_CP: begin
                o_res.result[BW-1:0] = a;
                o_res.write_back = 1'b0;
                o_res.flags.z = (sub_diff[BW-1:0] == '0);
                o_res.flags.n = 1'b1;
                o_res.flags.h = sub_half[NW];
                o_res.flags.c = sub_diff[BW];
            end
            cawf_pkg::KIND_AND: begin
                o_res.result[BW-1:0] = a & b;
                o_res.flags = '{z: ((a & b) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            cawf_pkg::KIND_XOR: begin
                o_res.result[BW-1:0] = a ^ b;
                o_res.flags = '{z: ((a ^ b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            cawf_pkg::KIND_OR: begin
                o_res.result[BW-1:0] = a | b;
                o_res.flags = '{z: ((a | b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            cawf_pkg::KIND_INC: begin
                o_res.result[BW-1:0] = inc_val;
                o_res.flags.z = (inc_val == '0);
                o_res.flags.n = 1'b0;
                o_res.flags.h = &b[NW-1:0];
            end
            cawf_pkg::KIND_DEC: begin
                o_res.result[BW-1:0] = dec_val;
                o_res.flags.z = (dec_val == '0);
                o_res.flags.n = 1'b1;
                o_res.flags.h = ~|b[NW-1:0];
            end
            cawf_pkg::KIND_DAA: begin
                o_res.result[BW-1:0] = daa_val;
                o_res.flags.z = (daa_val == '0);
                o_res.flags.h = 1'b0;
                o_res.flags.c = daa_c;
            end
            cawf_pkg::KIND_CPL: begin
                o_res.result[BW-1:0] = ~a;
                o_res.flags.n = 1'b1;
                o_res.flags.h = 1'b1;
            end
            cawf_pkg::KIND_SCF: begin
                o_res.result[BW-1:0] = a;
                o_res.write_back = 1'b0;
                o_res.flags.n = 1'b0;
                o_res.flags.h = 1'b0;
                o_res.flags.c = 1'b1;
            end
            cawf_pkg::KIND_CCF: begin
                o_res.result[BW-1:0] = a;
                o_res.write_back = 1'b0;
                o_res.flags.n = 1'b0;
                o_res.flags.h = 1'b0;
                o_res.flags.c = ~i_op.flags.c;
            end
            cawf_pkg::KIND_RLC, cawf_pkg::KIND_RRC, cawf_pkg::KIND_RL,
            cawf_pkg::KIND_RR, cawf_pkg::KIND_SLA, cawf_pkg::KIND_SRA,
            cawf_pkg::KIND_SWAP, cawf_pkg::KIND_SRL: begin
                o_res.result[BW-1:0] = shift_res.value;
                o_res.flags.z = (shift_res.value == '0);
                o_res.flags.n = 1'b0;
                o_res.flags.h = 1'b0;
                o_res.flags.c = shift_res.carry;
            end
            cawf_pkg::KIND_BIT: begin
                o_res.result[BW-1:0] = b;
                o_res.write_back = 1'b0;
                o_res.flags.z = ~b[i_op.bit_index];
                o_res.flags.n = 1'b0;
                o_res.flags.h = 1'b1;
            end
            cawf_pkg::KIND_RES: begin
                o_res.result[BW-1:0] = b & ~bit_mask;
            end
            cawf_pkg::KIND_SET: begin
                o_res.result[BW-1:0] = b | bit_mask;
            end
            cawf_pkg::KIND_ADD16: begin
                o_res.result  = w_sum[WW-1:0];
                o_res.flags.n = 1'b0;
                o_res.flags.h = w_half[12];
                o_res.flags.c = w_sum[WW];
            end
            cawf_pkg::KIND_ADDSP: begin
                // H and C come from the unsigned low-byte add of SP and the offset
                o_res.result  = sp_sum;
                o_res.flags.z = 1'b0;
                o_res.flags.n = 1'b0;
                o_res.flags.h = add_half[NW];
                o_res.flags.c = add_sum[BW];
            end
            default: begin
                o_res.result     = '0;
                o_res.write_back = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/cpu_alu_with_flags_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_core
// 8-bit ALU with Z/N/H/C flags and 16-bit HL/SP adds, one operation per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: tuser holds the operation
//   code, tdata the operands, bit index and incoming flags. m_axis returns one
//   transaction per operation: result, write-back mark and the new flags.
//   Datapath: input register -> single-pass ALU logic -> result register.
//   An accepted transaction is captured in the input register, then moves to
//   the result register and is offered on m_axis, earlier results permitting.
//   Throughput: one transaction per cycle sustained while m_axis_tready stays high; the critical path is the
//   16-bit add plus the result select between the two registers.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register still takes one more transaction, and s_axis_tready drops only
//   when both registers are full.
//   Reset: synchronous, active low; both stages are emptied, no result is
//   offered. Payload registers are not reset.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_core (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    // Operation in
    input  var logic                              s_axis_tvalid,
    output var logic                              s_axis_tready,
    // [15:0] operand_a, [31:16] operand_b, [34:32] bit_index,
    // [35] zero_in, [36] subtract_in, [37] half_in, [38] carry_in, [39] zero
    input  var logic [cawf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [4:0] kind
    input  var logic [cawf_pkg::KIND_W-1:0]       s_axis_tuser,
    // Result out
    output var logic                              m_axis_tvalid,
    input  var logic                              m_axis_tready,
    // [15:0] result, [16] write_back, [17] zero_out, [18] subtract_out,
    // [19] half_out, [20] carry_out, [23:21] zero
    output var logic [cawf_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int WW = cawf_pkg::WORD_W;
    localparam int IW = cawf_pkg::IDX_W;

    // Stage control
    logic r_in_valid;
    logic n_in_valid;
    logic r_out_valid;
    logic n_out_valid;
    logic advance;       // input stage may move into the result register
    logic in_take;       // s_axis transaction completes

    cawf_pkg::t_alu_in  r_in;
    cawf_pkg::t_alu_in  n_in;
    cawf_pkg::t_alu_out r_out;
    cawf_pkg::t_alu_out alu_res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming transaction
    always_comb begin
        n_in.kind      = cawf_pkg::t_kind'(s_axis_tuser);
        n_in.operand_a = s_axis_tdata[WW-1:0];
        n_in.operand_b = s_axis_tdata[2*WW-1:WW];
        n_in.bit_index = s_axis_tdata[2*WW+IW-1:2*WW];
        n_in.flags.z   = s_axis_tdata[2*WW+IW];
        n_in.flags.n   = s_axis_tdata[2*WW+IW+1];
        n_in.flags.h   = s_axis_tdata[2*WW+IW+2];
        n_in.flags.c   = s_axis_tdata[2*WW+IW+3];
    end

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= n_in;
        end
        if (advance && r_in_valid) begin
            r_out <= alu_res;
        end
    end

    cawf_alu u_alu (
        .i_op  (r_in),
        .o_res (alu_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{cawf_pkg::M_PAD_W{1'b0}},
                            r_out.flags.c, r_out.flags.h, r_out.flags.n, r_out.flags.z,
                            r_out.write_back, r_out.result};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("s_axis_tready low with a free stage");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("operation lost between input and result register");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled operation changed in input register");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result offered twice");

endmodule
`default_nettype wire
